// ----- design/pursp_pkg.sv -----
// shared types and constants for the picture unit register and scroll port
// no dependencies

package pursp_pkg;

   // frame timing
   localparam logic [8:0] DOTS_PER_LINE = 9'd341;
   localparam logic [8:0] LAST_LINE     = 9'd261;
   localparam logic [8:0] VBLANK_LINE   = 9'd241;
   localparam logic [8:0] VISIBLE_LINES = 9'd240;
   localparam logic [8:0] DOT_FINE_Y    = 9'd256;
   localparam logic [8:0] DOT_HORIZ     = 9'd257;
   localparam logic [8:0] DOT_VERT      = 9'd280;
   localparam logic [8:0] DOT_FLAG      = 9'd1;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 64;

   // request kinds
   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   // register numbers
   localparam logic [2:0] REG_CTRL     = 3'd0;
   localparam logic [2:0] REG_MASK     = 3'd1;
   localparam logic [2:0] REG_STATUS   = 3'd2;
   localparam logic [2:0] REG_OAM_ADDR = 3'd3;
   localparam logic [2:0] REG_OAM_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL   = 3'd5;
   localparam logic [2:0] REG_ADDR     = 3'd6;
   localparam logic [2:0] REG_DATA     = 3'd7;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] reg_index;
      logic [7:0] write_data;
      logic [7:0] vram_data;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [13:0] vid_addr;
      logic        vram_write_enable;
      logic [7:0]  vram_write_data;
      logic        oam_write_enable;
      logic [7:0]  oam_write_addr;
      logic [7:0]  oam_write_data;
      logic        palette_write_enable;
      logic [4:0]  palette_write_addr;
      logic [5:0]  palette_write_data;
      logic        palette_mirror;
      logic        vblank_flag;
   } rsp_item_type;

   // input stage to engine
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

endpackage

// ----- design/pursp_in_stage.sv -----
// input register of the register and scroll port
// depends on pursp_pkg

module pursp_in_stage
   import pursp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic         advance,
   input  req_item_type req_item,
   output stage_type    stage
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// ----- design/pursp_engine.sv -----
// register file, scroll address logic and dot counters
// depends on pursp_pkg

module pursp_engine
   import pursp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         commit,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [14:0] v_ff, v_in;
   logic [14:0] t_ff, t_in;
   logic [2:0]  fine_x_ff, fine_x_in;
   logic        toggle_ff, toggle_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic        vblank_ff, vblank_in;
   logic [7:0]  latch_ff, latch_in;
   logic [7:0]  rbuf_ff, rbuf_in;
   logic [7:0]  oam_addr_ff, oam_addr_in;
   logic [8:0]  dot_ff, dot_in;
   logic [8:0]  line_ff, line_in;

   function automatic logic [14:0] step_coarse_x(input logic [14:0] a);
      logic [14:0] r;
      r = a;
      if (a[4:0] == 5'd31) begin
         r[4:0] = 5'd0;
         r[10]  = ~a[10];
      end else begin
         r[4:0] = a[4:0] + 5'd1;
      end
      return r;
   endfunction

   function automatic logic [14:0] step_fine_y(input logic [14:0] a);
      logic [14:0] r;
      r = a;
      if (a[14:12] != 3'd7) begin
         r[14:12] = a[14:12] + 3'd1;
      end else begin
         r[14:12] = 3'd0;
         if (a[9:5] == 5'd29) begin
            r[9:5] = 5'd0;
            r[11]  = ~a[11];
         end else if (a[9:5] == 5'd31) begin
            r[9:5] = 5'd0;
         end else begin
            r[9:5] = a[9:5] + 5'd1;
         end
      end
      return r;
   endfunction

   // data port address step: linear outside rendering, scroll steps inside
   function automatic logic [14:0] step_v(input logic [14:0] a, input logic linear,
                                          input logic inc32);
      logic [14:0] r;
      if (linear) begin
         r = a + (inc32 ? 15'd32 : 15'd1);
      end else begin
         r = step_fine_y(step_coarse_x(a));
      end
      return r;
   endfunction

   logic       render_on;
   logic       visible;
   logic       linear;
   logic [8:0] dot_next;

   always_comb begin
      render_on = (mask_ff[3] | mask_ff[4]);
      visible   = (line_ff < VISIBLE_LINES);
      linear    = (line_ff >= VBLANK_LINE) || !render_on;
      dot_next  = dot_ff + 9'd1;

      v_in        = v_ff;
      t_in        = t_ff;
      fine_x_in   = fine_x_ff;
      toggle_in   = toggle_ff;
      ctrl_in     = ctrl_ff;
      mask_in     = mask_ff;
      vblank_in   = vblank_ff;
      latch_in    = latch_ff;
      rbuf_in     = rbuf_ff;
      oam_addr_in = oam_addr_ff;
      dot_in      = dot_ff;
      line_in     = line_ff;

      result          = '0;
      result.vid_addr = v_ff[13:0];

      unique case (func_type'(item.func))
         FUNC_READ: begin
            if (item.reg_index == REG_STATUS) begin
               result.read_data = {vblank_ff, 2'b00, latch_ff[4:0]};
               toggle_in        = 1'b0;
               vblank_in        = 1'b0;
            end else if (item.reg_index == REG_DATA) begin
               result.read_data = rbuf_ff;
               rbuf_in          = item.vram_data;
               v_in             = step_v(v_ff, linear, ctrl_ff[2]);
            end else begin
               result.read_data = latch_ff;
            end
         end
         FUNC_WRITE: begin
            latch_in = item.write_data;
            unique case (item.reg_index)
               REG_CTRL: begin
                  ctrl_in      = item.write_data;
                  t_in[11:10]  = item.write_data[1:0];
               end
               REG_MASK: begin
                  mask_in = item.write_data;
               end
               REG_OAM_ADDR: begin
                  oam_addr_in = item.write_data;
               end
               REG_OAM_DATA: begin
                  if (visible && render_on) begin
                     oam_addr_in = oam_addr_ff + 8'd4;
                  end else begin
                     result.oam_write_enable = 1'b1;
                     result.oam_write_addr   = oam_addr_ff;
                     // attribute byte has no bits 2..4
                     result.oam_write_data   = (oam_addr_ff[1:0] == 2'd2) ?
                                               (item.write_data & 8'hE3) : item.write_data;
                     oam_addr_in             = oam_addr_ff + 8'd1;
                  end
               end
               REG_SCROLL: begin
                  if (!toggle_ff) begin
                     t_in[4:0] = item.write_data[7:3];
                     fine_x_in = item.write_data[2:0];
                  end else begin
                     t_in[9:5]   = item.write_data[7:3];
                     t_in[14:12] = item.write_data[2:0];
                  end
                  toggle_in = ~toggle_ff;
               end
               REG_ADDR: begin
                  if (!toggle_ff) begin
                     t_in[14]   = 1'b0;
                     t_in[13:8] = item.write_data[5:0];
                  end else begin
                     t_in[7:0] = item.write_data;
                     v_in      = {t_ff[14:8], item.write_data};
                  end
                  toggle_in = ~toggle_ff;
               end
               REG_DATA: begin
                  if (v_ff[13:8] == 6'h3F) begin
                     result.palette_write_enable = 1'b1;
                     result.palette_write_addr   = v_ff[4:0];
                     result.palette_write_data   = item.write_data[5:0];
                     result.palette_mirror       = (v_ff[1:0] == 2'd0);
                     v_in = step_v(v_ff, linear, ctrl_ff[2]);
                  end else if (!visible || !render_on) begin
                     result.vram_write_enable = 1'b1;
                     result.vram_write_data   = item.write_data;
                     v_in = step_v(v_ff, linear, ctrl_ff[2]);
                  end else begin
                     // rendering conflict: address low byte lands in memory
                     result.vram_write_enable = 1'b1;
                     result.vram_write_data   = v_ff[7:0];
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_TICK: begin
            if (line_ff == VBLANK_LINE && dot_ff == DOT_FLAG) begin
               vblank_in = 1'b1;
            end
            if (line_ff == LAST_LINE && dot_ff == DOT_FLAG) begin
               vblank_in = 1'b0;
            end
            if (render_on && (visible || line_ff == LAST_LINE)) begin
               if (dot_ff == DOT_FINE_Y) begin
                  v_in = step_fine_y(v_ff);
               end else if (dot_ff == DOT_HORIZ) begin
                  v_in = (v_ff & ~15'h041F) | (t_ff & 15'h041F);
               end else if (line_ff == LAST_LINE && dot_ff == DOT_VERT) begin
                  v_in = t_ff;
               end
            end
            dot_in = dot_next;
            if (dot_next >= DOTS_PER_LINE || dot_next == 9'd0) begin
               dot_in  = 9'd0;
               line_in = line_ff + 9'd1;
               if (line_in > LAST_LINE) begin
                  line_in = 9'd0;
               end
            end
         end
         default: begin
         end
      endcase

      result.vblank_flag = vblank_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff        <= '0;
         t_ff        <= '0;
         fine_x_ff   <= '0;
         toggle_ff   <= 1'b0;
         ctrl_ff     <= '0;
         mask_ff     <= '0;
         vblank_ff   <= 1'b0;
         latch_ff    <= '0;
         rbuf_ff     <= '0;
         oam_addr_ff <= '0;
         dot_ff      <= '0;
         line_ff     <= '0;
      end else if (commit) begin
         v_ff        <= v_in;
         t_ff        <= t_in;
         fine_x_ff   <= fine_x_in;
         toggle_ff   <= toggle_in;
         ctrl_ff     <= ctrl_in;
         mask_ff     <= mask_in;
         vblank_ff   <= vblank_in;
         latch_ff    <= latch_in;
         rbuf_ff     <= rbuf_in;
         oam_addr_ff <= oam_addr_in;
         dot_ff      <= dot_in;
         line_ff     <= line_in;
      end
   end

endmodule

// ----- design/picture_unit_register_scroll_port_core.sv -----
// top level of the picture unit register and scroll port
// depends on pursp_pkg, pursp_in_stage, pursp_engine

// usage
// - req channel: one request per item: a cpu register read, a cpu register write
//   or one dot tick, selected by req_tuser; register number and bytes in req_tdata
// - rsp channel: exactly one response per request, in request order, carrying read
//   data, the video address, write strobes for video, sprite and palette memory,
//   and the vblank flag after the request
// - a request passes the input register, then the register and scroll logic into
//   the response register
// - throughput: one request per cycle unless rsp_tready stalls; the state update
//   for a request commits as its response is registered; the next sees it at once
// - req_tready stays high while the response register is free or is being drained;
//   a waiting response does not stop the input register from taking a request
// - when the receiver stalls, the response holds and the input register keeps one
//   request, after which req_tready falls
// - reset (synchronous, active high) clears both pipeline valid flags, the scroll
//   addresses, control, mask, latches and the dot and line counters

module picture_unit_register_scroll_port_core
   import pursp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] reg_index, [10:3] write_data, [18:11] vram_data, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] read_data, [21:8] vid_addr, [22] vram_write_enable,
   // [30:23] vram_write_data, [31] oam_write_enable, [39:32] oam_write_addr,
   // [47:40] oam_write_data, [48] palette_write_enable, [53:49] palette_write_addr,
   // [59:54] palette_write_data, [60] palette_mirror, [61] vblank_flag, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   req_item_type req_item;
   stage_type    stage;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         advance;
   logic         load;

   // unpack request
   assign req_item.func       = req_tuser;
   assign req_item.reg_index  = req_tdata[2:0];
   assign req_item.write_data = req_tdata[10:3];
   assign req_item.vram_data  = req_tdata[18:11];

   // the held request moves on whenever the response register is free or draining
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !stage.valid || advance;
   assign load       = req_tvalid && req_tready;

   pursp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .advance  (advance),
      .req_item (req_item),
      .stage    (stage)
   );

   // state commits together with the response register load
   pursp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .commit (stage.valid && advance),
      .item   (stage.item),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage.valid && advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_ff.vblank_flag,
                        rsp_ff.palette_mirror,
                        rsp_ff.palette_write_data,
                        rsp_ff.palette_write_addr,
                        rsp_ff.palette_write_enable,
                        rsp_ff.oam_write_data,
                        rsp_ff.oam_write_addr,
                        rsp_ff.oam_write_enable,
                        rsp_ff.vram_write_data,
                        rsp_ff.vram_write_enable,
                        rsp_ff.vid_addr,
                        rsp_ff.read_data};

endmodule

// ----- design/pursp_checker.sv -----
// port checker for the picture unit register and scroll port, bound to the top level
// depends on pursp_pkg and picture_unit_register_scroll_port_core

module pursp_port_props
   import pursp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a data port write goes to video or palette memory, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[22] && rsp_tdata[48]))
      else $error("video and palette write in one response");

   // nonzero read data never comes with a write strobe
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[7:0] != 8'd0) |->
         !rsp_tdata[22] && !rsp_tdata[31] && !rsp_tdata[48])
      else $error("read data together with a write strobe");

   // palette fields stay zero without the palette strobe
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[48] |-> (rsp_tdata[60:49] == 12'd0))
      else $error("palette fields set without palette write");

endmodule

bind picture_unit_register_scroll_port_core pursp_port_props u_pursp_port_props (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
